>>> rtl/nrpe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrpe_pkg
// shared types, constants and codes of the nand read/program/erase sequencer
// ----------------------------------------------------------------------------
package nrpe_pkg;

    // geometry, both powers of two
    localparam int PAGE_BYTES      = 2048;
    localparam int PAGES_PER_BLOCK = 64;
    localparam int BLOCK_BYTES     = PAGE_BYTES * PAGES_PER_BLOCK;
    localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);
    localparam int BLOCK_SHIFT     = $clog2(BLOCK_BYTES);

    // field widths
    localparam int TYPE_W  = 3;
    localparam int ADDR_W  = 28;
    localparam int LEN_W   = 29;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int ERR_W   = 2;
    localparam int PAGE_W  = 17;
    localparam int COL_W   = PAGE_SHIFT + 1;

    // results per input item
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    // request types
    localparam logic [TYPE_W-1:0] REQ_READ    = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_PROGRAM = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_ERASE   = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_HOST    = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_READY   = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_FLASH   = 3'd5;

    // cycle kinds
    localparam logic [KIND_W-1:0] KIND_CMD   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADDR  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WDATA = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RDATA = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE  = 3'd4;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_PROGRAM   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ERASE     = 2'd2;
    localparam logic [ERR_W-1:0] ERR_MISALIGN  = 2'd3;

    // nand commands
    localparam logic [BYTE_W-1:0] CMD_READ1   = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_READ2   = 8'h30;
    localparam logic [BYTE_W-1:0] CMD_PROG1   = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_PROG2   = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_STATUS  = 8'h70;
    localparam logic [BYTE_W-1:0] CMD_ERASE1  = 8'h60;
    localparam logic [BYTE_W-1:0] CMD_ERASE2  = 8'hD0;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [ADDR_W-1:0] byte_address;
        logic [LEN_W-1:0]  byte_length;
        logic [BYTE_W-1:0] data_byte;
    } req_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] value;
        logic [ERR_W-1:0]  err;
    } entry_t;

    typedef struct packed {
        logic [CNT_W-1:0]                 count;
        entry_t [MAX_RESULTS-1:0]         entry;
    } burst_t;

    function automatic entry_t mk_entry(logic [KIND_W-1:0] kind,
                                        logic [BYTE_W-1:0] value,
                                        logic [ERR_W-1:0]  err);
        entry_t e;
        e.kind  = kind;
        e.value = value;
        e.err   = err;
        return e;
    endfunction

endpackage
`default_nettype wire

>>> rtl/nrpe_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrpe_req_if
// request/event channel: valid, ready and one input item
// ----------------------------------------------------------------------------
interface nrpe_req_if;
    logic                          valid;
    logic                          ready;
    logic [nrpe_pkg::TYPE_W-1:0]   req_type;
    logic [nrpe_pkg::ADDR_W-1:0]   byte_address;
    logic [nrpe_pkg::LEN_W-1:0]    byte_length;
    logic [nrpe_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output req_type, output byte_address,
                    output byte_length, output data_byte, input ready);
    modport sink   (input valid, input req_type, input byte_address,
                    input byte_length, input data_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/nrpe_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrpe_res_if
// bus cycle channel: valid, ready and one result item
// ----------------------------------------------------------------------------
interface nrpe_res_if;
    logic                          valid;
    logic                          ready;
    logic [nrpe_pkg::KIND_W-1:0]   cycle_kind;
    logic [nrpe_pkg::BYTE_W-1:0]   cycle_value;
    logic [nrpe_pkg::ERR_W-1:0]    error_code;
    logic                          burst_last;

    modport source (output valid, output cycle_kind, output cycle_value,
                    output error_code, output burst_last, input ready);
    modport sink   (input valid, input cycle_kind, input cycle_value,
                    input error_code, input burst_last, output ready);
endinterface
`default_nettype wire

>>> rtl/nrpe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrpe_ctrl
// operation state and burst decode for one accepted item
// ----------------------------------------------------------------------------
module nrpe_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire nrpe_pkg::req_item_t item,
    output nrpe_pkg::burst_t         burst
);
    import nrpe_pkg::*;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_RD_WAIT = 8'b0000_0010,
        PH_RD_DATA = 8'b0000_0100,
        PH_PG_DATA = 8'b0000_1000,
        PH_PG_WAIT = 8'b0001_0000,
        PH_PG_STAT = 8'b0010_0000,
        PH_ER_WAIT = 8'b0100_0000,
        PH_ER_STAT = 8'b1000_0000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [LEN_W-1:0]    left_reg, left_next;

    logic                lead_en;
    entry_t              lead;
    logic                cmd_en;
    logic [BYTE_W-1:0]   cmd_code;
    logic                start_read, start_prog, start_erase;
    logic                done_en;
    logic [ERR_W-1:0]    done_err;
    logic [15:0]         col16;
    logic [23:0]         row24;
    logic [CNT_W-1:0]    cnt;
    entry_t [MAX_RESULTS-1:0] ent;

    always_comb
    begin
        phase_next  = phase_reg;
        page_next   = page_reg;
        col_next    = col_reg;
        left_next   = left_reg;
        lead_en     = 1'b0;
        lead        = mk_entry(KIND_CMD, '0, ERR_OK);
        cmd_en      = 1'b0;
        cmd_code    = CMD_STATUS;
        start_read  = 1'b0;
        start_prog  = 1'b0;
        start_erase = 1'b0;
        done_en     = 1'b0;
        done_err    = ERR_OK;

        case (item.req_type)
            REQ_READ, REQ_PROGRAM, REQ_ERASE:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    page_next = PAGE_W'(item.byte_address >> PAGE_SHIFT);
                    col_next  = COL_W'(item.byte_address[PAGE_SHIFT-1:0]);
                    left_next = item.byte_length;
                    if (item.req_type == REQ_ERASE)
                    begin
                        col_next = '0;
                        if (item.byte_address[BLOCK_SHIFT-1:0] != '0 ||
                            item.byte_length[BLOCK_SHIFT-1:0] != '0)
                        begin
                            done_en  = 1'b1;
                            done_err = ERR_MISALIGN;
                        end
                        else if (item.byte_length == '0)
                            done_en = 1'b1;
                        else
                            start_erase = 1'b1;
                    end
                    else if (item.byte_length == '0)
                        done_en = 1'b1;
                    else if (item.req_type == REQ_READ)
                        start_read = 1'b1;
                    else
                        start_prog = 1'b1;
                end
            end
            REQ_HOST:
            begin
                if (phase_reg == PH_PG_DATA)
                begin
                    lead_en   = 1'b1;
                    lead      = mk_entry(KIND_WDATA, item.data_byte, ERR_OK);
                    left_next = left_reg - 1'b1;
                    col_next  = col_reg + 1'b1;
                    if (left_next == '0 || col_next >= COL_W'(PAGE_BYTES))
                    begin
                        cmd_en     = 1'b1;
                        cmd_code   = CMD_PROG2;
                        phase_next = PH_PG_WAIT;
                    end
                end
            end
            REQ_READY:
            begin
                if (phase_reg == PH_RD_WAIT)
                    phase_next = PH_RD_DATA;
                else if (phase_reg == PH_PG_WAIT)
                begin
                    cmd_en     = 1'b1;
                    phase_next = PH_PG_STAT;
                end
                else if (phase_reg == PH_ER_WAIT)
                begin
                    cmd_en     = 1'b1;
                    phase_next = PH_ER_STAT;
                end
            end
            REQ_FLASH:
            begin
                if (phase_reg == PH_RD_DATA)
                begin
                    lead_en   = 1'b1;
                    lead      = mk_entry(KIND_RDATA, item.data_byte, ERR_OK);
                    left_next = left_reg - 1'b1;
                    col_next  = col_reg + 1'b1;
                    if (left_next == '0)
                        done_en = 1'b1;
                    else if (col_next >= COL_W'(PAGE_BYTES))
                    begin
                        page_next  = page_reg + 1'b1;
                        col_next   = '0;
                        start_read = 1'b1;
                    end
                end
                else if (phase_reg == PH_PG_STAT)
                begin
                    if (item.data_byte[0])
                    begin
                        done_en  = 1'b1;
                        done_err = ERR_PROGRAM;
                    end
                    else
                    begin
                        page_next = page_reg + 1'b1;
                        col_next  = '0;
                        if (left_reg == '0)
                            done_en = 1'b1;
                        else
                            start_prog = 1'b1;
                    end
                end
                else if (phase_reg == PH_ER_STAT)
                begin
                    if (item.data_byte[0])
                    begin
                        done_en  = 1'b1;
                        done_err = ERR_ERASE;
                    end
                    else
                    begin
                        left_next = (left_reg >= LEN_W'(BLOCK_BYTES)) ?
                                    left_reg - LEN_W'(BLOCK_BYTES) : '0;
                        page_next = page_reg + PAGE_W'(PAGES_PER_BLOCK);
                        if (left_next == '0)
                            done_en = 1'b1;
                        else
                            start_erase = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (start_read)
            phase_next = PH_RD_WAIT;
        if (start_prog)
            phase_next = PH_PG_DATA;
        if (start_erase)
            phase_next = PH_ER_WAIT;
        if (done_en)
            phase_next = PH_IDLE;
    end

    // burst assembly in bus order
    always_comb
    begin
        col16 = 16'(col_next);
        row24 = 24'(page_next);
        ent   = '0;
        cnt   = '0;
        if (lead_en)
        begin
            ent[cnt[IDX_W-1:0]] = lead;
            cnt = cnt + 1'b1;
        end
        if (cmd_en)
        begin
            ent[cnt[IDX_W-1:0]] = mk_entry(KIND_CMD, cmd_code, ERR_OK);
            cnt = cnt + 1'b1;
        end
        if (start_read || start_prog || start_erase)
        begin
            ent[cnt[IDX_W-1:0]] = mk_entry(KIND_CMD,
                start_read ? CMD_READ1 : (start_prog ? CMD_PROG1 : CMD_ERASE1), ERR_OK);
            cnt = cnt + 1'b1;
            if (!start_erase)
            begin
                ent[cnt[IDX_W-1:0]] = mk_entry(KIND_ADDR, col16[7:0], ERR_OK);
                cnt = cnt + 1'b1;
                ent[cnt[IDX_W-1:0]] = mk_entry(KIND_ADDR, col16[15:8], ERR_OK);
                cnt = cnt + 1'b1;
            end
            ent[cnt[IDX_W-1:0]] = mk_entry(KIND_ADDR, row24[7:0], ERR_OK);
            cnt = cnt + 1'b1;
            ent[cnt[IDX_W-1:0]] = mk_entry(KIND_ADDR, row24[15:8], ERR_OK);
            cnt = cnt + 1'b1;
            ent[cnt[IDX_W-1:0]] = mk_entry(KIND_ADDR, row24[23:16], ERR_OK);
            cnt = cnt + 1'b1;
            if (start_read || start_erase)
            begin
                ent[cnt[IDX_W-1:0]] = mk_entry(KIND_CMD,
                    start_read ? CMD_READ2 : CMD_ERASE2, ERR_OK);
                cnt = cnt + 1'b1;
            end
        end
        if (done_en)
        begin
            ent[cnt[IDX_W-1:0]] = mk_entry(KIND_DONE, '0, done_err);
            cnt = cnt + 1'b1;
        end
        burst.count = cnt;
        burst.entry = ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            page_reg  <= '0;
            col_reg   <= '0;
            left_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            page_reg  <= page_next;
            col_reg   <= col_next;
            left_reg  <= left_next;
        end
    end

endmodule
`default_nettype wire

>>> rtl/nrpe_burst.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrpe_burst
// result buffer: holds one burst and drains it, while res is ready, one transfer per cycle
// ----------------------------------------------------------------------------
module nrpe_burst (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire nrpe_pkg::burst_t burst,
    output logic                  can_load,
    nrpe_res_if.source            res
);
    import nrpe_pkg::*;

    logic [CNT_W-1:0]         count_reg;
    logic [IDX_W-1:0]         idx_reg;
    entry_t [MAX_RESULTS-1:0] ent_reg;
    entry_t                   cur;
    logic                     last;
    logic                     pop;

    assign cur      = ent_reg[idx_reg];
    assign last     = (CNT_W'(idx_reg) + 1'b1) == count_reg;
    assign pop      = res.valid && res.ready;
    assign can_load = (count_reg == '0) || (pop && last);

    assign res.valid       = count_reg != '0;
    assign res.cycle_kind  = cur.kind;
    assign res.cycle_value = cur.value;
    assign res.error_code  = cur.err;
    assign res.burst_last  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else if (load && burst.count != '0)
        begin
            count_reg <= burst.count;
            idx_reg   <= '0;
        end
        else if (pop)
        begin
            if (last)
                count_reg <= '0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && burst.count != '0)
            ent_reg <= burst.entry;
    end

endmodule
`default_nettype wire

>>> rtl/nand_read_program_erase_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nand_read_program_erase_sequencer
// turns read, program and erase requests into nand command, address and
// data bus cycles, page by page or block by block
// ----------------------------------------------------------------------------
// An item on req is decoded in the cycle it transfers and its bus cycles
// (up to eight) are loaded into a result buffer, which sends one transfer
// per cycle on res while res is ready. An item that causes results holds
// the block until its last result transfers: req is ready whenever the
// buffer is empty or its last result transfers in the same cycle, so a
// stream of host or flash bytes that each cause one result runs at one
// item per cycle while res is ready. Pages are PAGE_BYTES bytes and blocks
// PAGES_PER_BLOCK pages; there is no clearing pass after reset.
module nand_read_program_erase_sequencer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    nrpe_req_if.sink   req,
    nrpe_res_if.source res
);
    import nrpe_pkg::*;

    req_item_t item;
    burst_t    burst;
    logic      can_load;
    logic      take;

    assign item.req_type     = req.req_type;
    assign item.byte_address = req.byte_address;
    assign item.byte_length  = req.byte_length;
    assign item.data_byte    = req.data_byte;

    assign req.ready = can_load;
    assign take      = req.valid && can_load;

    nrpe_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (item),
        .burst (burst)
    );

    nrpe_burst u_burst (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .burst    (burst),
        .can_load (can_load),
        .res      (res)
    );

endmodule
`default_nettype wire

>>> rtl/nrpe_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nrpe_checker
// port-level checks of the sequencer, bound to the top level
// ----------------------------------------------------------------------------
module nrpe_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        req_ready,
    input wire logic                        res_valid,
    input wire logic                        res_ready,
    input wire logic [nrpe_pkg::KIND_W-1:0] res_kind,
    input wire logic [nrpe_pkg::BYTE_W-1:0] res_value,
    input wire logic [nrpe_pkg::ERR_W-1:0]  res_err,
    input wire logic                        res_last
);
    import nrpe_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_kind) &&
        $stable(res_value) && $stable(res_err) && $stable(res_last))
        else $error("stalled result changed");

    // done always closes a burst
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_DONE |-> res_last)
        else $error("done result not last in burst");

    // error code only on done
    a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind != KIND_DONE |-> res_err == ERR_OK)
        else $error("error code on non-done result");

    // requests stall only behind pending results
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> res_valid)
        else $error("request stalled with no pending result");

endmodule

bind nand_read_program_erase_sequencer nrpe_checker u_nrpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_kind  (res.cycle_kind),
    .res_value (res.cycle_value),
    .res_err   (res.error_code),
    .res_last  (res.burst_last)
);
`default_nettype wire

>>> dv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the nand read/program/erase sequencer. A short
// table of directed items (zero lengths, misaligned erases, page and block
// wrap at the top of the array, failed status, requests and events that
// must be ignored) is followed by random read, program and erase sequences
// driven by the tracked sequencer state, with some noise mixed in. Every bus
// cycle on the result channel is checked against an in-bench prediction,
// with random idling on both channels and one long hold-off on the results.
// ----------------------------------------------------------------------------
module tb_top;
    import nrpe_pkg::*;

    localparam logic [TYPE_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS     = 260;
    localparam int SINK_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int TAIL_CYCLES      = 16;
    localparam int MAX_REPORTS      = 10;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD_WAIT, ST_RD_DATA, ST_PG_DATA,
        ST_PG_WAIT, ST_PG_STAT, ST_ER_WAIT, ST_ER_STAT
    } seq_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] value;
        logic [ERR_W-1:0]  err;
        logic              last;
    } bus_cycle_t;

    typedef struct packed {
        req_item_t        item;
        logic             typed;
        logic [ERR_W-1:0] err;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    nrpe_req_if req ();
    nrpe_res_if res ();

    nand_read_program_erase_sequencer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // tracked sequencer state
    seq_state_t        seq_state;
    logic [PAGE_W-1:0] seq_page;
    logic [COL_W-1:0]  seq_col;
    logic [LEN_W-1:0]  seq_left;

    bus_cycle_t step_cycles[$];
    bus_cycle_t expected_cycles[$];
    stim_row_t  directed_rows[$];

    int  mismatches    = 0;
    int  cycles_seen   = 0;
    int  useful_items  = 0;
    int  reads_run     = 0;
    int  programs_run  = 0;
    int  erases_run    = 0;
    int  failed_ops    = 0;
    int  idle_cycles   = 0;
    int  stalls_asked  = 0;
    int  stalls_served = 0;
    int  hold_left     = 0;
    bit  steady        = 1'b0;

    function automatic void emit_cycle(input logic [KIND_W-1:0] kind,
                                       input logic [BYTE_W-1:0] value,
                                       input logic [ERR_W-1:0]  err);
        bus_cycle_t c;
        c.kind  = kind;
        c.value = value;
        c.err   = err;
        c.last  = 1'b0;
        if (step_cycles.size() < MAX_RESULTS)
            step_cycles.push_back(c);
    endfunction

    function automatic void emit_row();
        emit_cycle(KIND_ADDR, seq_page[7:0], ERR_OK);
        emit_cycle(KIND_ADDR, seq_page[15:8], ERR_OK);
        emit_cycle(KIND_ADDR, BYTE_W'(seq_page >> 16), ERR_OK);
    endfunction

    function automatic void emit_column_and_row();
        emit_cycle(KIND_ADDR, seq_col[7:0], ERR_OK);
        emit_cycle(KIND_ADDR, BYTE_W'(seq_col >> 8), ERR_OK);
        emit_row();
    endfunction

    function automatic void finish_op(input logic [ERR_W-1:0] err);
        emit_cycle(KIND_DONE, 8'h00, err);
        if (err != ERR_OK)
            failed_ops++;
        seq_state = ST_IDLE;
    endfunction

    function automatic void open_read_page();
        emit_cycle(KIND_CMD, CMD_READ1, ERR_OK);
        emit_column_and_row();
        emit_cycle(KIND_CMD, CMD_READ2, ERR_OK);
        seq_state = ST_RD_WAIT;
    endfunction

    function automatic void open_program_page();
        emit_cycle(KIND_CMD, CMD_PROG1, ERR_OK);
        emit_column_and_row();
        seq_state = ST_PG_DATA;
    endfunction

    function automatic void open_erase_block();
        emit_cycle(KIND_CMD, CMD_ERASE1, ERR_OK);
        emit_row();
        emit_cycle(KIND_CMD, CMD_ERASE2, ERR_OK);
        seq_state = ST_ER_WAIT;
    endfunction

    // bus cycles caused by one accepted item, left in step_cycles
    function automatic void predict_bus_cycles(input req_item_t it);
        bus_cycle_t tail;
        step_cycles.delete();
        case (it.req_type)
            REQ_READ, REQ_PROGRAM, REQ_ERASE:
            begin
                if (seq_state == ST_IDLE)
                begin
                    seq_page = it.byte_address[ADDR_W-1:PAGE_SHIFT];
                    seq_col  = COL_W'(it.byte_address[PAGE_SHIFT-1:0]);
                    seq_left = it.byte_length;
                    if (it.req_type == REQ_ERASE)
                    begin
                        erases_run++;
                        seq_col = '0;
                        if (it.byte_address[BLOCK_SHIFT-1:0] != '0 ||
                            it.byte_length[BLOCK_SHIFT-1:0] != '0)
                            finish_op(ERR_MISALIGN);
                        else if (seq_left == '0)
                            finish_op(ERR_OK);
                        else
                            open_erase_block();
                    end
                    else
                    begin
                        if (it.req_type == REQ_READ)
                            reads_run++;
                        else
                            programs_run++;
                        if (seq_left == '0)
                            finish_op(ERR_OK);
                        else if (it.req_type == REQ_READ)
                            open_read_page();
                        else
                            open_program_page();
                    end
                end
            end
            REQ_HOST:
            begin
                if (seq_state == ST_PG_DATA)
                begin
                    emit_cycle(KIND_WDATA, it.data_byte, ERR_OK);
                    seq_left = seq_left - 1'b1;
                    seq_col  = seq_col + 1'b1;
                    if (seq_left == '0 || seq_col >= PAGE_BYTES)
                    begin
                        emit_cycle(KIND_CMD, CMD_PROG2, ERR_OK);
                        seq_state = ST_PG_WAIT;
                    end
                end
            end
            REQ_READY:
            begin
                case (seq_state)
                    ST_RD_WAIT:
                        seq_state = ST_RD_DATA;
                    ST_PG_WAIT:
                    begin
                        emit_cycle(KIND_CMD, CMD_STATUS, ERR_OK);
                        seq_state = ST_PG_STAT;
                    end
                    ST_ER_WAIT:
                    begin
                        emit_cycle(KIND_CMD, CMD_STATUS, ERR_OK);
                        seq_state = ST_ER_STAT;
                    end
                    default:
                    begin
                    end
                endcase
            end
            REQ_FLASH:
            begin
                case (seq_state)
                    ST_RD_DATA:
                    begin
                        emit_cycle(KIND_RDATA, it.data_byte, ERR_OK);
                        seq_left = seq_left - 1'b1;
                        seq_col  = seq_col + 1'b1;
                        if (seq_left == '0)
                            finish_op(ERR_OK);
                        else if (seq_col >= PAGE_BYTES)
                        begin
                            seq_page = seq_page + 1'b1;
                            seq_col  = '0;
                            open_read_page();
                        end
                    end
                    ST_PG_STAT:
                    begin
                        if (it.data_byte[0])
                            finish_op(ERR_PROGRAM);
                        else
                        begin
                            seq_page = seq_page + 1'b1;
                            seq_col  = '0;
                            if (seq_left == '0)
                                finish_op(ERR_OK);
                            else
                                open_program_page();
                        end
                    end
                    ST_ER_STAT:
                    begin
                        if (it.data_byte[0])
                            finish_op(ERR_ERASE);
                        else
                        begin
                            seq_left = (seq_left >= BLOCK_BYTES) ?
                                       seq_left - LEN_W'(BLOCK_BYTES) : '0;
                            seq_page = seq_page + PAGE_W'(PAGES_PER_BLOCK);
                            if (seq_left == '0)
                                finish_op(ERR_OK);
                            else
                                open_erase_block();
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        if (step_cycles.size() > 0)
        begin
            tail = step_cycles.pop_back();
            tail.last = 1'b1;
            step_cycles.push_back(tail);
        end
    endfunction

    function automatic logic [TYPE_W-1:0] awaited_event();
        case (seq_state)
            ST_RD_DATA, ST_PG_STAT, ST_ER_STAT: return REQ_FLASH;
            ST_PG_DATA:                         return REQ_HOST;
            default:                            return REQ_READY;
        endcase
    endfunction

    function automatic void add_row(input logic [TYPE_W-1:0] kind,
                                    input logic [ADDR_W-1:0] addr,
                                    input logic [LEN_W-1:0]  len,
                                    input logic [BYTE_W-1:0] data,
                                    input logic              typed,
                                    input logic [ERR_W-1:0]  err);
        stim_row_t r;
        r.item.req_type     = kind;
        r.item.byte_address = addr;
        r.item.byte_length  = len;
        r.item.data_byte    = data;
        r.typed             = typed;
        r.err               = err;
        directed_rows.push_back(r);
    endfunction

    function automatic req_item_t random_fields(input logic [TYPE_W-1:0] kind);
        req_item_t it;
        it.req_type     = kind;
        it.byte_address = ADDR_W'($urandom);
        it.byte_length  = LEN_W'($urandom);
        it.data_byte    = BYTE_W'($urandom);
        return it;
    endfunction

    // offer one item, wait for its transfer, then record what it must cause
    task automatic send_item(input req_item_t it, input logic typed,
                             input logic [ERR_W-1:0] typed_err);
        bus_cycle_t c;
        while (!steady && $urandom_range(99) < 33)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid        <= 1'b1;
        req.req_type     <= it.req_type;
        req.byte_address <= it.byte_address;
        req.byte_length  <= it.byte_length;
        req.data_byte    <= it.data_byte;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        predict_bus_cycles(it);
        if (typed)
        begin
            c.kind  = KIND_DONE;
            c.value = 8'h00;
            c.err   = typed_err;
            c.last  = 1'b1;
            expected_cycles.push_back(c);
        end
        else
        begin
            foreach (step_cycles[i])
                expected_cycles.push_back(step_cycles[i]);
        end
    endtask

    task automatic issue(input req_item_t it);
        send_item(it, 1'b0, ERR_OK);
        useful_items++;
    endtask

    // something the busy sequencer must ignore
    task automatic send_noise();
        req_item_t it;
        it = random_fields(REQ_READ);
        case ($urandom_range(2))
            0: it.req_type = TYPE_W'($urandom_range(REQ_READ, REQ_ERASE));
            1: it.req_type = $urandom_range(1) ? REQ_SPARE_LO : REQ_SPARE_HI;
            default:
            begin
                it.req_type = TYPE_W'($urandom_range(REQ_HOST, REQ_FLASH));
                if (it.req_type == awaited_event())
                    it.req_type = (it.req_type == REQ_READY) ? REQ_HOST : REQ_READY;
            end
        endcase
        send_item(it, 1'b0, ERR_OK);
    endtask

    task automatic feed_until_idle();
        req_item_t it;
        logic      fail;
        while (seq_state != ST_IDLE)
        begin
            if ($urandom_range(99) < 6)
                send_noise();
            else
            begin
                it = random_fields(awaited_event());
                if (seq_state == ST_PG_STAT || seq_state == ST_ER_STAT)
                begin
                    // long operations are cut short by a failed status
                    fail = (seq_state == ST_PG_STAT) ? (seq_left > 64)
                                                     : (seq_left > 3 * BLOCK_BYTES);
                    it.data_byte[0] = fail || ($urandom_range(99) < 12);
                end
                issue(it);
            end
        end
    endtask

    task automatic random_operation();
        req_item_t it;
        int        pick;
        pick = $urandom_range(99);
        it   = random_fields(REQ_READ);
        if (pick < 60)
        begin
            it.req_type = (pick < 30) ? REQ_READ : REQ_PROGRAM;
            if ($urandom_range(9) < 3)
                it.byte_address[PAGE_SHIFT-1:0] =
                    PAGE_SHIFT'(PAGE_BYTES - $urandom_range(1, 8));
            case ($urandom_range(9))
                0: it.byte_length = '0;
                1:
                begin
                    if (it.req_type == REQ_PROGRAM)
                    begin
                        it.byte_address[PAGE_SHIFT-1:0] =
                            PAGE_SHIFT'(PAGE_BYTES - $urandom_range(1, 4));
                        it.byte_length = LEN_W'($urandom_range(65, 32'h1FFFFFFF));
                    end
                    else
                        it.byte_length = LEN_W'($urandom_range(1, 24));
                end
                default: it.byte_length = LEN_W'($urandom_range(1, 24));
            endcase
        end
        else if (pick < 85)
        begin
            it.req_type = REQ_ERASE;
            case ($urandom_range(9))
                0:
                begin
                end
                1:
                begin
                    it.byte_address[BLOCK_SHIFT-1:0] = '0;
                    it.byte_length = '0;
                end
                2:
                begin
                    it.byte_address[BLOCK_SHIFT-1:0] = '0;
                    it.byte_length = LEN_W'($urandom_range(4, 2048)) << BLOCK_SHIFT;
                end
                default:
                begin
                    it.byte_address[BLOCK_SHIFT-1:0] = '0;
                    it.byte_length = LEN_W'($urandom_range(1, 3)) << BLOCK_SHIFT;
                end
            endcase
        end
        else
        begin
            // events and spare types while idle
            it.req_type = TYPE_W'($urandom_range(REQ_HOST, REQ_SPARE_HI));
            send_item(it, 1'b0, ERR_OK);
            return;
        end
        issue(it);
        feed_until_idle();
    endtask

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // stimulus
    initial
    begin : stimulus
        req_item_t it;
        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.req_type     = REQ_SPARE_HI;
        req.byte_address = '0;
        req.byte_length  = '0;
        req.data_byte    = '0;
        seq_state        = ST_IDLE;
        seq_page         = '0;
        seq_col          = '0;
        seq_left         = '0;

        //      type          address      length        data   typed  error
        add_row(REQ_READ,     28'h0000000, 29'h0000000,  8'h00, 1'b1, ERR_OK);
        add_row(REQ_PROGRAM,  28'hFFFFFFF, 29'h0000000,  8'hFF, 1'b1, ERR_OK);
        add_row(REQ_ERASE,    28'h0000800, 29'h0020000,  8'h00, 1'b1, ERR_MISALIGN);
        add_row(REQ_ERASE,    28'h0000000, 29'h1FFFFFFF, 8'h00, 1'b1, ERR_MISALIGN);
        add_row(REQ_ERASE,    28'h0000000, 29'h0000000,  8'h00, 1'b1, ERR_OK);
        add_row(REQ_READY,    28'h0000000, 29'h0000000,  8'h00, 1'b0, ERR_OK);
        add_row(REQ_SPARE_LO, 28'hFFFFFFF, 29'h1FFFFFFF, 8'hFF, 1'b0, ERR_OK);
        add_row(REQ_SPARE_HI, 28'h0000000, 29'h0000000,  8'h00, 1'b0, ERR_OK);
        // last column of the last page, the page address wraps
        add_row(REQ_READ,     28'hFFFFFFF, 29'h0000002,  8'h00, 1'b0, ERR_OK);
        add_row(REQ_READY,    28'h0000000, 29'h0000000,  8'h00, 1'b0, ERR_OK);
        add_row(REQ_FLASH,    28'h0000000, 29'h0000000,  8'hFF, 1'b0, ERR_OK);
        add_row(REQ_READ,     28'h0000005, 29'h0000005,  8'h00, 1'b0, ERR_OK);
        add_row(REQ_HOST,     28'h0000000, 29'h0000000,  8'h5A, 1'b0, ERR_OK);
        add_row(REQ_READY,    28'h0000000, 29'h0000000,  8'h00, 1'b0, ERR_OK);
        add_row(REQ_FLASH,    28'h0000000, 29'h0000000,  8'h00, 1'b0, ERR_OK);
        add_row(REQ_PROGRAM,  28'h00007FF, 29'h10000000, 8'h00, 1'b0, ERR_OK);
        add_row(REQ_HOST,     28'h0000000, 29'h0000000,  8'hA5, 1'b0, ERR_OK);
        add_row(REQ_FLASH,    28'h0000000, 29'h0000000,  8'h00, 1'b0, ERR_OK);
        add_row(REQ_READY,    28'h0000000, 29'h0000000,  8'h00, 1'b0, ERR_OK);
        add_row(REQ_FLASH,    28'h0000000, 29'h0000000,  8'h01, 1'b1, ERR_PROGRAM);
        // last block, the second block wraps to row zero
        add_row(REQ_ERASE,    28'hFFE0000, 29'h0040000,  8'h00, 1'b0, ERR_OK);
        add_row(REQ_READY,    28'h0000000, 29'h0000000,  8'h00, 1'b0, ERR_OK);
        add_row(REQ_FLASH,    28'h0000000, 29'h0000000,  8'hFE, 1'b0, ERR_OK);
        add_row(REQ_READY,    28'h0000000, 29'h0000000,  8'h00, 1'b0, ERR_OK);
        add_row(REQ_FLASH,    28'h0000000, 29'h0000000,  8'h00, 1'b1, ERR_OK);
        add_row(REQ_ERASE,    28'h0020000, 29'h10000000, 8'h00, 1'b0, ERR_OK);
        add_row(REQ_READY,    28'h0000000, 29'h0000000,  8'h00, 1'b0, ERR_OK);
        add_row(REQ_FLASH,    28'h0000000, 29'h0000000,  8'h01, 1'b1, ERR_ERASE);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].err);

        // results held off while a program page keeps offering bytes
        stalls_asked++;
        it = random_fields(REQ_PROGRAM);
        it.byte_address[PAGE_SHIFT-1:0] = '0;
        it.byte_length = LEN_W'(40);
        issue(it);
        feed_until_idle();

        useful_items = 0;
        while (useful_items < RANDOM_ITEMS)
        begin
            steady = (useful_items >= 110 && useful_items < 170);
            random_operation();
        end
        steady = 1'b0;

        req.valid <= 1'b0;
        while (expected_cycles.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d directed and %0d random items: %0d reads, %0d programs,",
                 directed_rows.size(), useful_items, reads_run, programs_run);
        $display("%0d erases, %0d failed or misaligned, %0d bus cycles checked, %0d mismatches",
                 erases_run, failed_ops, cycles_seen, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // result channel ready, with a long hold-off on request
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stalls_served != stalls_asked)
            begin
                stalls_served++;
                hold_left = SINK_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= steady || ($urandom_range(99) >= 33);
        end
    end

    // result check
    always @(posedge clk)
    begin : result_check
        bus_cycle_t got;
        bus_cycle_t want;
        if (rst_n && res.valid && res.ready)
        begin
            got.kind  = res.cycle_kind;
            got.value = res.cycle_value;
            got.err   = res.error_code;
            got.last  = res.burst_last;
            cycles_seen++;
            if (expected_cycles.size() == 0)
                report_error($sformatf("unexpected transfer: kind %0d value %02h err %0d last %0b",
                                       got.kind, got.value, got.err, got.last));
            else
            begin
                want = expected_cycles.pop_front();
                if (got.kind != want.kind || got.value != want.value ||
                    got.err != want.err || got.last != want.last)
                    report_error($sformatf(
                        "cycle %0d: exp kind %0d value %02h err %0d last %0b, got %0d %02h %0d %0b",
                        cycles_seen, want.kind, want.value, want.err, want.last,
                        got.kind, got.value, got.err, got.last));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (res.valid && res.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles, %0d cycles still expected",
                         idle_cycles, expected_cycles.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire
